[rtl/qct_pkg.sv]
`default_nettype none

package qct_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [1:0] quote_t;

  localparam kind_t K_CHAR       = 3'd0;
  localparam kind_t K_WEND       = 3'd1;
  localparam kind_t K_OK         = 3'd2;
  localparam kind_t K_COMMENT    = 3'd3;
  localparam kind_t K_INCOMPLETE = 3'd4;

  localparam quote_t Q_NONE   = 2'd0;
  localparam quote_t Q_DOUBLE = 2'd1;
  localparam quote_t Q_SINGLE = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_HASH   = 8'd35;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [5:0] idx;
    logic       last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic quote_t quote_code(input logic [7:0] c);
    quote_t q;
    case (c)
      CH_DQUOTE: q = Q_DOUBLE;
      CH_SQUOTE: q = Q_SINGLE;
      default:   q = Q_NONE;
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

[rtl/qct_if.sv]
`default_nettype none

interface qct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface qct_out_if;
  logic             valid;
  logic             ready;
  qct_pkg::kind_t   kind;
  logic [7:0]       out_ch;
  logic [5:0]       word_index;
  logic             last;

  modport source (output valid, output kind, output out_ch, output word_index,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_ch, input word_index,
                  input last, output ready);
endinterface

`default_nettype wire

[rtl/quoted_command_tokenizer.sv]
`default_nettype none

// Splits a command line, one character per input word, into words with
// quotes removed and backslash escapes resolved, and reports ok, comment or
// incomplete at line end. Each character is handled in the cycle it is taken,
// so a new character can be accepted every cycle while input ready is high; it
// yields zero, one or two result words, which go into a four-entry result
// queue. Input ready is high while the queue holds at most two words, so with
// the output side always ready the block sustains one character per cycle and
// stalls only after a character that yields two results (a kept backslash, or a
// word end followed by line ok). Word indexes saturate at MAX_WORDS minus one.
module quoted_command_tokenizer #(
  parameter int MAX_WORDS = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  qct_in_if.sink     in_chan,
  qct_out_if.source  out_chan
);
  import qct_pkg::*;

  localparam int WC_W = $clog2(MAX_WORDS);

  quote_t          bound_quote_r, bound_quote_nxt;
  logic            bound_escape_r, bound_escape_nxt;
  quote_t          unesc_quote_r, unesc_quote_nxt;
  logic            unesc_escape_r, unesc_escape_nxt;
  logic            raw_mode_r, raw_mode_nxt;
  logic            in_word_r, in_word_nxt;
  logic [WC_W-1:0] word_count_r, word_count_nxt;
  logic            comment_mode_r, comment_mode_nxt;

  res_t            fifo_r [4];
  logic [1:0]      wr_ptr_r, rd_ptr_r;
  logic [2:0]      cnt_r;

  logic            acc, pop, eol, do_char, kept;
  logic [7:0]      c;
  logic [WC_W-1:0] wc_inc;
  logic [5:0]      idx_cur, idx_inc;
  quote_t          wbq, wuq;
  logic            wbe, wue, wraw;
  logic [1:0]      n;
  res_t            r0, r1;

  assign acc = in_chan.valid && in_chan.ready;
  assign pop = out_chan.valid && out_chan.ready;
  assign c   = in_chan.ch;
  assign eol = in_chan.line_end || (c == CH_NUL);

  assign wc_inc  = (word_count_r < WC_W'(MAX_WORDS - 1)) ? word_count_r + 1'b1
                                                          : word_count_r;
  assign idx_cur = 6'(word_count_r);
  assign idx_inc = 6'(wc_inc);

  always_comb begin
    bound_quote_nxt  = bound_quote_r;
    bound_escape_nxt = bound_escape_r;
    unesc_quote_nxt  = unesc_quote_r;
    unesc_escape_nxt = unesc_escape_r;
    raw_mode_nxt     = raw_mode_r;
    in_word_nxt      = in_word_r;
    word_count_nxt   = word_count_r;
    comment_mode_nxt = comment_mode_r;
    do_char = 1'b0;
    kept    = 1'b0;
    wbq  = bound_quote_r;
    wbe  = bound_escape_r;
    wuq  = unesc_quote_r;
    wue  = unesc_escape_r;
    wraw = raw_mode_r;
    n  = 2'd0;
    r0 = '{kind: K_CHAR, ch: 8'd0, idx: idx_cur, last: 1'b0};
    r1 = '{kind: K_CHAR, ch: 8'd0, idx: idx_cur, last: 1'b0};

    if (eol) begin
      if (comment_mode_r) begin
        r0.kind = K_COMMENT;
        n = 2'd1;
      end else if (in_word_r && bound_quote_r != Q_NONE) begin
        r0.kind = K_INCOMPLETE;
        n = 2'd1;
      end else if (in_word_r) begin
        r0.kind = K_WEND;
        r1.kind = K_OK;
        r1.idx  = idx_inc;
        n = 2'd2;
      end else begin
        r0.kind = K_OK;
        n = 2'd1;
      end
      bound_quote_nxt  = Q_NONE;
      bound_escape_nxt = 1'b0;
      unesc_quote_nxt  = Q_NONE;
      unesc_escape_nxt = 1'b0;
      raw_mode_nxt     = 1'b0;
      in_word_nxt      = 1'b0;
      word_count_nxt   = '0;
      comment_mode_nxt = 1'b0;
    end else if (comment_mode_r) begin
      n = 2'd0;
    end else if (!in_word_r) begin
      if (is_space(c)) begin
        n = 2'd0;
      end else if (word_count_r == '0 && c == CH_HASH) begin
        comment_mode_nxt = 1'b1;
      end else begin
        in_word_nxt = 1'b1;
        wbq  = Q_NONE;
        wbe  = 1'b0;
        wuq  = Q_NONE;
        wue  = 1'b0;
        wraw = 1'b0;
        do_char = 1'b1;
      end
    end else if (!bound_escape_r && bound_quote_r == Q_NONE && is_space(c)) begin
      r0.kind = K_WEND;
      n = 2'd1;
      word_count_nxt   = wc_inc;
      in_word_nxt      = 1'b0;
      bound_quote_nxt  = Q_NONE;
      bound_escape_nxt = 1'b0;
      unesc_quote_nxt  = Q_NONE;
      unesc_escape_nxt = 1'b0;
      raw_mode_nxt     = 1'b0;
    end else begin
      do_char = 1'b1;
    end

    if (do_char) begin
      bound_quote_nxt  = wbq;
      bound_escape_nxt = 1'b0;
      if (wbe) begin
        bound_escape_nxt = 1'b0;
      end else if (wbq == Q_NONE) begin
        if (quote_code(c) != Q_NONE) begin
          bound_quote_nxt = quote_code(c);
        end else if (c == CH_BSLASH) begin
          bound_escape_nxt = 1'b1;
        end
      end else begin
        if (quote_code(c) == wbq) begin
          bound_quote_nxt = Q_NONE;
        end else if (wbq == Q_DOUBLE && c == CH_BSLASH) begin
          bound_escape_nxt = 1'b1;
        end
      end

      unesc_quote_nxt  = wuq;
      unesc_escape_nxt = 1'b0;
      raw_mode_nxt     = wraw;
      if (wue) begin
        if (wuq == Q_NONE) begin
          kept = quote_code(c) != Q_NONE || c == CH_BSLASH || is_space(c);
        end else begin
          kept = c == CH_DQUOTE || c == CH_BSLASH;
        end
        if (kept) begin
          r0.ch = c;
          n = 2'd1;
        end else begin
          r0.ch = CH_BSLASH;
          r1.ch = c;
          n = 2'd2;
        end
      end else if (wraw || (c == CH_HASH && wuq == Q_NONE)) begin
        raw_mode_nxt = 1'b1;
        r0.ch = c;
        n = 2'd1;
      end else if (wuq == Q_NONE) begin
        if (quote_code(c) != Q_NONE) begin
          unesc_quote_nxt = quote_code(c);
        end else if (c == CH_BSLASH) begin
          unesc_escape_nxt = 1'b1;
        end else begin
          r0.ch = c;
          n = 2'd1;
        end
      end else begin
        if (quote_code(c) == wuq) begin
          unesc_quote_nxt = Q_NONE;
        end else if (wuq == Q_DOUBLE && c == CH_BSLASH) begin
          unesc_escape_nxt = 1'b1;
        end else begin
          r0.ch = c;
          n = 2'd1;
        end
      end
    end

    r0.last = (n == 2'd1);
    r1.last = (n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_quote_r  <= Q_NONE;
      bound_escape_r <= 1'b0;
      unesc_quote_r  <= Q_NONE;
      unesc_escape_r <= 1'b0;
      raw_mode_r     <= 1'b0;
      in_word_r      <= 1'b0;
      word_count_r   <= '0;
      comment_mode_r <= 1'b0;
    end else if (acc) begin
      bound_quote_r  <= bound_quote_nxt;
      bound_escape_r <= bound_escape_nxt;
      unesc_quote_r  <= unesc_quote_nxt;
      unesc_escape_r <= unesc_escape_nxt;
      raw_mode_r     <= raw_mode_nxt;
      in_word_r      <= in_word_nxt;
      word_count_r   <= word_count_nxt;
      comment_mode_r <= comment_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && n != 2'd0) begin
      fifo_r[wr_ptr_r] <= r0;
    end
    if (acc && n == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + (acc ? n : 2'd0);
      rd_ptr_r <= rd_ptr_r + {1'b0, pop};
      cnt_r    <= cnt_r + (acc ? {1'b0, n} : 3'd0) - {2'b00, pop};
    end
  end

  assign in_chan.ready       = (cnt_r < 3'd3);
  assign out_chan.valid      = (cnt_r != 3'd0);
  assign out_chan.kind       = fifo_r[rd_ptr_r].kind;
  assign out_chan.out_ch     = fifo_r[rd_ptr_r].ch;
  assign out_chan.word_index = fifo_r[rd_ptr_r].idx;
  assign out_chan.last       = fifo_r[rd_ptr_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result queue overflow");

  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && eol |=> !in_word_r && !comment_mode_r && word_count_r == '0)
    else $error("line state not cleared at line end");

  a_comment_excl: assert property (@(posedge clk) disable iff (!rst_n)
    comment_mode_r |-> !in_word_r && word_count_r == '0)
    else $error("comment line with open word or counted words");

  a_raw_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    raw_mode_r |-> in_word_r)
    else $error("raw tail outside a word");

endmodule

`default_nettype wire

[tb/sv/quoted_command_tokenizer_tb.sv]
`timescale 1ns / 100ps

module quoted_command_tokenizer_tb;
  import qct_pkg::*;

  localparam int MAX_WORDS = 64;
  localparam int DIRECTED_CHARS = 26;
  localparam int RANDOM_CHARS = 624;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam int PICK_PLAIN = 0;
  localparam int PICK_SQ    = 1;
  localparam int PICK_DQ    = 2;

  localparam int SIDE_IN  = 0;
  localparam int SIDE_OUT = 1;

  typedef struct {
    logic [7:0] c;
    logic       le;
    bit         hold_idle;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_ch = 8'd0;
  logic       drv_le = 1'b0;
  logic       sink_ready = 1'b0;
  logic       in_took = 1'b0;

  qct_in_if  in_chan();
  qct_out_if out_chan();

  assign in_chan.valid    = drv_valid;
  assign in_chan.ch       = drv_ch;
  assign in_chan.line_end = drv_le;
  assign out_chan.ready   = sink_ready;

  quoted_command_tokenizer #(.MAX_WORDS(MAX_WORDS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  char_item_t char_feed[$];
  res_t       token_fifo[$];
  res_t       step_res[$];
  bit         drain_pending = 1'b0;

  // splitter state
  quote_t     bq;
  logic       besc;
  quote_t     uq;
  logic       uesc;
  logic       raw;
  logic       open_word;
  logic [6:0] wcount;
  logic       cmt;

  int errors = 0;
  int chars_taken = 0;
  int lines_seen = 0;
  int words_checked = 0;
  int comment_lines = 0;
  int incomplete_lines = 0;
  int gap_left = 0;
  int stall_left = 0;
  int calm_left[2] = '{0, 0};

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic quote_t quote_of(input logic [7:0] c);
    if (c == CH_DQUOTE) return Q_DOUBLE;
    if (c == CH_SQUOTE) return Q_SINGLE;
    return Q_NONE;
  endfunction

  function void emit(input kind_t k, input logic [7:0] v);
    res_t r;
    r.kind = k;
    r.ch = v;
    r.idx = wcount[5:0];
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function void bump_words();
    if (wcount < MAX_WORDS - 1) wcount++;
  endfunction

  function void reset_word_state();
    bq = Q_NONE;
    besc = 1'b0;
    uq = Q_NONE;
    uesc = 1'b0;
    raw = 1'b0;
  endfunction

  function void track_bounds(input logic [7:0] c);
    if (besc) begin
      besc = 1'b0;
    end else if (bq == Q_NONE) begin
      if (quote_of(c) != Q_NONE) bq = quote_of(c);
      else if (c == CH_BSLASH) besc = 1'b1;
    end else begin
      if (quote_of(c) == bq) bq = Q_NONE;
      else if (bq == Q_DOUBLE && c == CH_BSLASH) besc = 1'b1;
    end
  endfunction

  function void unescape(input logic [7:0] c);
    bit kept;
    if (uesc) begin
      uesc = 1'b0;
      if (uq == Q_NONE) kept = quote_of(c) != Q_NONE || c == CH_BSLASH || is_blank(c);
      else kept = c == CH_DQUOTE || c == CH_BSLASH;
      if (!kept) emit(K_CHAR, CH_BSLASH);
      emit(K_CHAR, c);
    end else if (raw || (c == CH_HASH && uq == Q_NONE)) begin
      raw = 1'b1;
      emit(K_CHAR, c);
    end else if (uq == Q_NONE) begin
      if (quote_of(c) != Q_NONE) uq = quote_of(c);
      else if (c == CH_BSLASH) uesc = 1'b1;
      else emit(K_CHAR, c);
    end else begin
      if (quote_of(c) == uq) uq = Q_NONE;
      else if (uq == Q_DOUBLE && c == CH_BSLASH) uesc = 1'b1;
      else emit(K_CHAR, c);
    end
  endfunction

  function void tokenize_char(input logic [7:0] c, input logic le);
    step_res.delete();
    if (le || c == CH_NUL) begin
      lines_seen++;
      if (cmt) begin
        emit(K_COMMENT, 8'd0);
        comment_lines++;
      end else if (open_word && bq != Q_NONE) begin
        emit(K_INCOMPLETE, 8'd0);
        incomplete_lines++;
      end else begin
        if (open_word) begin
          emit(K_WEND, 8'd0);
          bump_words();
        end
        emit(K_OK, 8'd0);
      end
      reset_word_state();
      open_word = 1'b0;
      wcount = '0;
      cmt = 1'b0;
    end else if (cmt) begin
    end else if (!open_word) begin
      if (is_blank(c)) begin
      end else if (wcount == 0 && c == CH_HASH) begin
        cmt = 1'b1;
      end else begin
        open_word = 1'b1;
        reset_word_state();
        track_bounds(c);
        unescape(c);
      end
    end else if (!besc && bq == Q_NONE && is_blank(c)) begin
      emit(K_WEND, 8'd0);
      bump_words();
      open_word = 1'b0;
      reset_word_state();
    end else begin
      track_bounds(c);
      unescape(c);
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) token_fifo.push_back(step_res[i]);
  endfunction

  function int idle_len(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) calm_left[side] = $urandom_range(20, 60);
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function logic [7:0] pick_byte(input int ctx);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while ((ctx == PICK_PLAIN && (is_blank(b) || b == CH_HASH || b == CH_BSLASH ||
                                      quote_of(b) != Q_NONE)) ||
               (ctx == PICK_SQ && b == CH_SQUOTE) ||
               (ctx == PICK_DQ && (b == CH_DQUOTE || b == CH_BSLASH)));
    return b;
  endfunction

  function logic [7:0] pick_blank();
    logic [7:0] r;
    r = 8'($urandom_range(8, 13));
    return (r == 8'd8) ? CH_SPACE : r;
  endfunction

  function logic [7:0] pick_escaped();
    case ($urandom_range(0, 4))
      0: return CH_DQUOTE;
      1: return CH_SQUOTE;
      2: return CH_BSLASH;
      3: return pick_blank();
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task feed_char(input logic [7:0] c, input logic le = 1'b0);
    char_item_t it;
    it.c = c;
    it.le = le;
    it.hold_idle = drain_pending;
    drain_pending = 1'b0;
    char_feed.push_back(it);
  endtask

  task feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_char(s[i]);
  endtask

  task feed_blanks(input int min_n);
    repeat ($urandom_range(min_n, 3)) feed_char(pick_blank());
  endtask

  task feed_line_end();
    if ($urandom_range(0, 1)) feed_char(8'($urandom_range(0, 255)), 1'b1);
    else feed_char(CH_NUL);
  endtask

  task feed_word();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 3)) feed_char(pick_byte(PICK_PLAIN));
        4: begin
          feed_char(CH_SQUOTE);
          repeat ($urandom_range(0, 4)) feed_char(pick_byte(PICK_SQ));
          feed_char(CH_SQUOTE);
        end
        5, 6: begin
          feed_char(CH_DQUOTE);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
              feed_char(CH_BSLASH);
              feed_char(pick_escaped());
            end else begin
              feed_char(pick_byte(PICK_DQ));
            end
          end
          feed_char(CH_DQUOTE);
        end
        7, 8: begin
          feed_char(CH_BSLASH);
          feed_char(pick_escaped());
        end
        default: feed_char(CH_HASH);
      endcase
    end
  endtask

  task feed_random_line(input int line_no);
    int sel;
    int nw;
    logic [7:0] q;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) drain_pending = 1'b1;
    if (line_no == 12) begin
      // overflow the word counter with one-character words
      nw = $urandom_range(MAX_WORDS, MAX_WORDS + 8);
      for (int w = 0; w < nw; w++) begin
        feed_blanks(1);
        feed_char(pick_byte(PICK_PLAIN));
      end
    end else if (sel < 70) begin
      nw = $urandom_range(0, 6);
      feed_blanks(0);
      for (int w = 0; w < nw; w++) begin
        if (w > 0) feed_blanks(1);
        feed_word();
      end
      if ($urandom_range(0, 1)) feed_blanks(0);
    end else if (sel < 78) begin
      feed_blanks(0);
      feed_char(CH_HASH);
      repeat ($urandom_range(0, 8)) feed_char(8'($urandom_range(1, 255)));
    end else if (sel < 90) begin
      nw = $urandom_range(0, 2);
      for (int w = 0; w < nw; w++) begin
        feed_blanks(1);
        feed_word();
      end
      if ($urandom_range(0, 1)) feed_blanks(1);
      case ($urandom_range(0, 2))
        0: begin
          q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
          feed_char(q);
          repeat ($urandom_range(0, 4))
            feed_char(pick_byte(q == CH_SQUOTE ? PICK_SQ : PICK_DQ));
        end
        1: begin
          feed_char(CH_DQUOTE);
          repeat ($urandom_range(0, 3)) feed_char(pick_byte(PICK_DQ));
          feed_char(CH_BSLASH);
        end
        default: begin
          feed_word();
          feed_char(CH_BSLASH);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 12)) feed_char(8'($urandom_range(0, 255)));
    end
    feed_line_end();
  endtask

  task check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
      errors++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    res_t e;
    in_took <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        tokenize_char(in_chan.ch, in_chan.line_end);
        chars_taken++;
      end
      if (out_chan.valid && out_chan.ready) begin
        words_checked++;
        if (token_fifo.size() == 0) begin
          $error("unexpected result word: kind %0d ch %0d index %0d last %0d",
                 out_chan.kind, out_chan.out_ch, out_chan.word_index, out_chan.last);
          errors++;
        end else begin
          e = token_fifo.pop_front();
          check_field("kind", int'(e.kind), int'(out_chan.kind));
          check_field("out_ch", int'(e.ch), int'(out_chan.out_ch));
          check_field("word_index", int'(e.idx), int'(out_chan.word_index));
          check_field("last", int'(e.last), int'(out_chan.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    char_item_t it;
    if (rst_n && !(drv_valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        drv_valid <= 1'b0;
      end else if (char_feed.size() > 0 &&
                   !(char_feed[0].hold_idle && token_fifo.size() != 0)) begin
        it = char_feed.pop_front();
        drv_ch <= it.c;
        drv_le <= it.le;
        drv_valid <= 1'b1;
        gap_left = idle_len(SIDE_IN);
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
      stall_left = idle_len(SIDE_OUT);
    end
  end

  initial begin
    int line_no;
    bq = Q_NONE;
    besc = 1'b0;
    uq = Q_NONE;
    uesc = 1'b0;
    raw = 1'b0;
    open_word = 1'b0;
    wcount = '0;
    cmt = 1'b0;

    feed_char(8'hff, 1'b1);
    feed_text("#x");
    feed_char(CH_NUL);
    feed_char(8'hff);
    feed_char(CH_TAB);
    feed_text("\\q\\ \"\\\"\\z\"");
    feed_char(8'h01);
    feed_text("#'");
    feed_char(CH_SPACE, 1'b1);
    feed_text("a\\");
    feed_char(CH_NUL, 1'b1);
    feed_text("\"\\");
    feed_char(CH_NUL);

    drain_pending = 1'b1;
    line_no = 0;
    while (char_feed.size() < DIRECTED_CHARS + RANDOM_CHARS) begin
      feed_random_line(line_no);
      line_no++;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_feed.size() != 0 || drv_valid || token_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (token_fifo.size() != 0) begin
      $error("%0d expected result words never arrived", token_fifo.size());
      errors++;
    end

    $display("Fed %0d characters in %0d lines, checked %0d result words", chars_taken,
             lines_seen, words_checked);
    $display("Lines ending as comment: %0d, as incomplete: %0d", comment_lines,
             incomplete_lines);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
